### rtl/assert_macros.svh
// Assertion macros shared by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define IALE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("list engine assertion failed");
`define IALE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("list engine assertion failed");
`else
`define IALE_ASSERT_SAME(lbl, ante, cons)
`define IALE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/iale_pkg.sv
// Types and constants of the indexed array list engine.
package iale_pkg;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned FND_W   = 4;
	localparam int unsigned ACT_W   = 2;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned APB_AW  = 3;
	localparam int unsigned APB_DW  = 32;

	localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;
	localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVF   = 2'd1;
	localparam logic [STAT_W-1:0] ST_INV   = 2'd2;
	localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic              ins;
		logic              del;
		logic              cmp;
		logic [POS_W-1:0]  pos;
		logic [CNT_W-1:0]  len;
		logic [DATA_W-1:0] value;
	} cmd_t;
endpackage

### rtl/iale_req_if.sv
// Request channel of the list engine: one action per beat.
interface iale_req_if;
	logic                             valid;
	logic                             ready;
	logic [iale_pkg::ACT_W-1:0]       action;
	logic signed [iale_pkg::DATA_W-1:0] value;
	logic [iale_pkg::POS_W-1:0]       position;

	modport source (output valid, action, value, position, input ready);
	modport sink (input valid, action, value, position, output ready);
endinterface

### rtl/iale_rsp_if.sv
// Response channel of the list engine: one result per beat.
interface iale_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [iale_pkg::STAT_W-1:0] status;
	logic [iale_pkg::FND_W-1:0]  found_position;
	logic [iale_pkg::CNT_W-1:0]  entry_count;

	modport source (output valid, status, found_position, entry_count, input ready);
	modport sink (input valid, status, found_position, entry_count, output ready);
endinterface

### rtl/iale_cell.sv
// One list slot: holds an entry, shifts with its neighbors and compares on search.
module iale_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                          clk,
	input  iale_pkg::cmd_t                cmd,
	input  logic [iale_pkg::DATA_W-1:0]   left,
	input  logic [iale_pkg::DATA_W-1:0]   right,
	output logic [iale_pkg::DATA_W-1:0]   data,
	output logic                          match
);
	logic [iale_pkg::DATA_W-1:0] data_q;
	logic                        match_q;
	logic [31:0]                 pos_w;
	logic [31:0]                 len_w;
	logic                        take_val;
	logic                        take_left;
	logic                        take_right;

	assign pos_w = 32'(cmd.pos);
	assign len_w = 32'(cmd.len);

	// Insert opens a hole at pos; cells above it up to the old length move up.
	assign take_val   = cmd.ins && (IDX == pos_w);
	assign take_left  = cmd.ins && (IDX > pos_w) && (IDX <= len_w);
	// Delete closes the gap: cells from pos below the last entry pull from above.
	assign take_right = cmd.del && (IDX >= pos_w) && (IDX + 1 < len_w);

	always_ff @(posedge clk) begin
		if (take_val) begin
			data_q <= cmd.value;
		end else if (take_left) begin
			data_q <= left;
		end else if (take_right) begin
			data_q <= right;
		end
		if (cmd.cmp) begin
			match_q <= (data_q == cmd.value) && (IDX < len_w);
		end
	end

	assign data  = data_q;
	assign match = match_q;
endmodule

### rtl/indexed_array_list_engine.sv
// Indexed array list engine: a packed list of signed 32-bit entries kept in a row of
// DEPTH cells that shift together. Append, insert and delete update the cells and the
// registered response together; a new action is taken when no unaccepted response is
// held. A search has every cell compare its entry against the key, then picks the
// lowest matching slot while ready is held low. Each action gives one response beat with
// status, found position and the entry count after the action. The capacity register
// sits at APB address 0 (reset 16); the list counts as full at min(capacity, DEPTH).
// Entries hold no reset value and need no clearing; only slots below the count are read.
`include "assert_macros.svh"
module indexed_array_list_engine #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	iale_req_if.sink                      req,
	iale_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [iale_pkg::APB_AW-1:0]   paddr,
	input  logic [iale_pkg::APB_DW-1:0]   pwdata,
	output logic [iale_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SRCH = 1'b1;

	logic                          state_q;
	logic [iale_pkg::CNT_W-1:0]    len_q;
	logic [iale_pkg::CNT_W-1:0]    cap_q;
	logic                          out_valid_q;
	logic [iale_pkg::STAT_W-1:0]   status_q;
	logic [iale_pkg::FND_W-1:0]    found_q;
	logic [iale_pkg::CNT_W-1:0]    count_q;

	iale_pkg::cmd_t                cmd;
	logic [iale_pkg::DATA_W-1:0]   cell_data [DEPTH];
	logic [DEPTH-1:0]              cell_match;

	logic                          acc;
	logic                          full;
	logic                          load;
	logic [iale_pkg::STAT_W-1:0]   status_d;
	logic [iale_pkg::FND_W-1:0]    found_d;
	logic [iale_pkg::CNT_W-1:0]    len_d;
	logic [iale_pkg::FND_W-1:0]    hit_pos;

	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;
	assign full      = (32'(len_q) >= 32'(cap_q)) || (32'(len_q) >= DEPTH);

	// Decode the action; an append is an insert at the current end.
	always_comb begin
		cmd.ins   = 1'b0;
		cmd.del   = 1'b0;
		cmd.cmp   = 1'b0;
		cmd.pos   = req.position;
		cmd.len   = len_q;
		cmd.value = req.value;
		status_d  = iale_pkg::ST_OK;
		len_d     = len_q;
		unique case (req.action)
			iale_pkg::ACT_APPEND: begin
				cmd.pos = len_q;
				if (full) begin
					status_d = iale_pkg::ST_OVF;
				end else begin
					cmd.ins = acc;
					len_d   = len_q + 5'd1;
				end
			end
			iale_pkg::ACT_INSERT: begin
				if (req.position > len_q) begin
					status_d = iale_pkg::ST_INV;
				end else if (full) begin
					status_d = iale_pkg::ST_OVF;
				end else begin
					cmd.ins = acc;
					len_d   = len_q + 5'd1;
				end
			end
			iale_pkg::ACT_DELETE: begin
				if (req.position >= len_q) begin
					status_d = iale_pkg::ST_INV;
				end else begin
					cmd.del = acc;
					len_d   = len_q - 5'd1;
				end
			end
			default: begin
				cmd.cmp = acc;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [iale_pkg::DATA_W-1:0] left;
		logic [iale_pkg::DATA_W-1:0] right;
		if (i == 0) begin : g_first
			assign left = cell_data[i];
		end else begin : g_mid_l
			assign left = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right = cell_data[i];
		end else begin : g_mid_r
			assign right = cell_data[i+1];
		end
		iale_cell #(.IDX(i)) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.left  (left),
			.right (right),
			.data  (cell_data[i]),
			.match (cell_match[i])
		);
	end

	// Lowest matching slot; positions wrap to the width of the found field.
	always_comb begin
		hit_pos = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (cell_match[i]) begin
				hit_pos = iale_pkg::FND_W'(i);
			end
		end
	end

	assign load = (state_q == ST_SRCH) || (acc && (req.action != iale_pkg::ACT_SEARCH));
	always_comb begin
		found_d = '0;
		if (state_q == ST_SRCH) begin
			found_d = (|cell_match) ? hit_pos : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			cap_q       <= iale_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (req.action == iale_pkg::ACT_SEARCH) begin
							state_q <= ST_SRCH;
						end else begin
							len_q <= len_d;
						end
					end
				end
				ST_SRCH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (psel && penable && pwrite && !paddr[2]) begin
				cap_q <= pwdata[iale_pkg::CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (state_q == ST_SRCH) begin
				status_q <= (|cell_match) ? iale_pkg::ST_OK : iale_pkg::ST_MISS;
			end else begin
				status_q <= status_d;
			end
			found_q <= found_d;
			count_q <= (state_q == ST_SRCH) ? len_q : len_d;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.found_position = found_q;
	assign rsp.entry_count    = count_q;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? '0 : iale_pkg::APB_DW'(cap_q);

	`IALE_ASSERT_NEXT(a_result_follows, acc && (req.action != iale_pkg::ACT_SEARCH), rsp.valid)
	`IALE_ASSERT_NEXT(a_search_blocks, acc && (req.action == iale_pkg::ACT_SEARCH), !req.ready && !rsp.valid)
	`IALE_ASSERT_NEXT(a_len_holds, !acc, $stable(len_q))
	`IALE_ASSERT_SAME(a_len_bounded, state_q == ST_SRCH, 32'(len_q) <= DEPTH)
endmodule
